@@ design/reb_pkg.sv @@
package reb_pkg;

    localparam int TIMER_CAP_DEF = 10000;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int STEP_W        = 17;
    localparam int TICK_W        = 14;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [7:0] SCAN_CCW    = 8'hd2;
    localparam logic [7:0] SCAN_CW     = 8'he1;
    localparam logic [7:0] SCAN_CLOSE  = 8'hc0;
    localparam logic [7:0] SETTLE_IDLE = 8'd255;
    localparam int         MIN_PRESS   = 5;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_BUTTON = 2'd1,
        OP_PINS   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        EV_ROT    = 2'd0,
        EV_LONG   = 2'd1,
        EV_CLICK  = 2'd2,
        EV_DOUBLE = 2'd3
    } ev_kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ACCEL_ENABLE   = 3'd0,
        REG_ACCEL_MAX_STEP = 3'd1,
        REG_ACCEL_HOLD     = 3'd2,
        REG_DOUBLE_ENABLE  = 3'd3,
        REG_DEBOUNCE       = 3'd4,
        REG_LONG_PRESS     = 3'd5,
        REG_DOUBLE_WINDOW  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic               accel_enable;
        logic [15:0]        accel_max_step;
        logic [7:0]         accel_hold_ticks;
        logic               double_click_enable;
        logic [7:0]         debounce_ticks;
        logic [TICK_W-1:0]  long_press_ticks;
        logic [TICK_W-1:0]  double_window_ticks;
    } cfg_t;

    typedef struct packed {
        ev_kind_t                  kind;
        logic signed [STEP_W-1:0]  step;
        logic                      last;
    } res_t;

endpackage

@@ design/reb_core.sv @@
module reb_core #(
    parameter int TIMER_CAP = reb_pkg::TIMER_CAP_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  reb_pkg::cfg_t     cfg,
    input  logic              accept,
    input  logic [1:0]        op,
    input  logic              button_level,
    input  logic              pin_a,
    input  logic              pin_b,
    output logic [1:0]        res_cnt,
    output reb_pkg::res_t [1:0] res
);
    import reb_pkg::*;

    localparam int TW = $clog2(TIMER_CAP + 1);
    localparam logic [TW-1:0] CAP = TW'(TIMER_CAP);

    logic [1:0]    last_pins_reg, last_pins_next;
    logic [7:0]    scan_reg, scan_next;
    logic          raw_reg, raw_next;
    logic [7:0]    settle_reg, settle_next;
    logic          stable_reg, stable_next;
    logic [TW-1:0] press_reg, press_next;
    logic [TW-1:0] gap_reg, gap_next;
    logic [7:0]    accel_left_reg, accel_left_next;
    logic [15:0]   accel_cnt_reg, accel_cnt_next;

    logic [1:0]         now;
    logic [STEP_W-1:0]  mag;
    logic [TICK_W-1:0]  limit;
    logic [1:0]         n;
    res_t [1:0]         r;

    assign now   = {pin_b, pin_a};
    assign mag   = {1'b0, accel_cnt_reg} + STEP_W'(1);
    assign limit = cfg.double_click_enable ? cfg.double_window_ticks : TICK_W'(1);

    always_comb begin
        last_pins_next  = last_pins_reg;
        scan_next       = scan_reg;
        raw_next        = raw_reg;
        settle_next     = settle_reg;
        stable_next     = stable_reg;
        press_next      = press_reg;
        gap_next        = gap_reg;
        accel_left_next = accel_left_reg;
        accel_cnt_next  = accel_cnt_reg;
        n               = 2'd0;
        r               = '0;

        if (accept) begin
            case (op)
                OP_TICK: begin
                    if (settle_reg != SETTLE_IDLE) begin
                        settle_next = settle_reg + 8'd1;
                        if (settle_next == cfg.debounce_ticks)
                            stable_next = raw_reg;
                    end

                    if (!stable_next && press_reg < CAP) begin
                        press_next = press_reg + TW'(1);
                        if (TICK_W'(press_next) == cfg.long_press_ticks) begin
                            r[n[0]].kind = EV_LONG;
                            n = n + 2'd1;
                        end
                    end

                    if (gap_reg < CAP) begin
                        gap_next = gap_reg + TW'(1);
                        if (TICK_W'(gap_next) == limit) begin
                            gap_next = CAP;
                            r[n[0]].kind = EV_CLICK;
                            n = n + 2'd1;
                        end
                    end

                    // qualifying release: open the window or close it as a double
                    if (stable_next) begin
                        if (press_next > TW'(MIN_PRESS) &&
                            TICK_W'(press_next) < cfg.long_press_ticks) begin
                            if (TICK_W'(gap_next) > cfg.double_window_ticks) begin
                                gap_next = '0;
                            end else if (TICK_W'(gap_next) < cfg.double_window_ticks) begin
                                gap_next = CAP;
                                r[n[0]].kind = EV_DOUBLE;
                                n = n + 2'd1;
                            end
                        end
                        press_next = '0;
                    end

                    if (accel_left_reg != 8'd0) begin
                        accel_left_next = accel_left_reg - 8'd1;
                        if (mag < {1'b0, cfg.accel_max_step})
                            accel_cnt_next = accel_cnt_reg + 16'd1;
                    end else begin
                        accel_cnt_next = '0;
                    end
                end
                OP_BUTTON: begin
                    raw_next    = button_level;
                    settle_next = '0;
                end
                OP_PINS: begin
                    if (now != last_pins_reg) begin
                        if (last_pins_reg == 2'd3) begin
                            scan_next = (now == 2'd1 || now == 2'd2) ? {6'd0, now} : 8'd0;
                        end else if (last_pins_reg == 2'd1 || last_pins_reg == 2'd2) begin
                            if (now == 2'd3) begin
                                // detent complete: check the whole sequence
                                if ((scan_reg | SCAN_CLOSE) == SCAN_CCW) begin
                                    if (cfg.accel_enable)
                                        accel_left_next = cfg.accel_hold_ticks;
                                    r[0].kind = EV_ROT;
                                    r[0].step = -$signed(mag);
                                    n = 2'd1;
                                end else if ((scan_reg | SCAN_CLOSE) == SCAN_CW) begin
                                    if (cfg.accel_enable)
                                        accel_left_next = cfg.accel_hold_ticks;
                                    r[0].kind = EV_ROT;
                                    r[0].step = $signed(mag);
                                    n = 2'd1;
                                end
                                scan_next = '0;
                            end else if (now == 2'd1 || now == 2'd2) begin
                                scan_next = '0;
                            end
                        end else begin
                            if (now == 2'd1 || now == 2'd2)
                                scan_next = scan_reg | {2'd0, now, 4'd0};
                            else
                                scan_next = '0;
                        end
                        last_pins_next = now;
                    end
                end
                default: ;
            endcase
        end

        if (n == 2'd2)
            r[1].last = 1'b1;
        else if (n == 2'd1)
            r[0].last = 1'b1;
    end

    assign res_cnt = n;
    assign res     = r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pins_reg  <= 2'd3;
            scan_reg       <= '0;
            raw_reg        <= 1'b1;
            settle_reg     <= SETTLE_IDLE;
            stable_reg     <= 1'b1;
            press_reg      <= CAP;
            gap_reg        <= CAP;
            accel_left_reg <= '0;
            accel_cnt_reg  <= '0;
        end else begin
            last_pins_reg  <= last_pins_next;
            scan_reg       <= scan_next;
            raw_reg        <= raw_next;
            settle_reg     <= settle_next;
            stable_reg     <= stable_next;
            press_reg      <= press_next;
            gap_reg        <= gap_next;
            accel_left_reg <= accel_left_next;
            accel_cnt_reg  <= accel_cnt_next;
        end
    end

endmodule

@@ design/reb_queue.sv @@
module reb_queue #(
    parameter int DEPTH = reb_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          push_cnt,
    input  reb_pkg::res_t [1:0] push_data,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output reb_pkg::res_t       out_data
);
    import reb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    res_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign out_data  = mem[rd_ptr_reg];
    // two free slots cover the worst case of one input beat
    assign room      = count_reg <= CW'(DEPTH - 2);

    assign wr_ptr_next = wr_ptr_reg + AW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign count_next  = count_reg + CW'(push_cnt) - CW'(pop);

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0)
            mem[wr_ptr_reg] <= push_data[0];
        if (push_cnt == 2'd2)
            mem[wr_ptr_reg + AW'(1)] <= push_data[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/rotary_encoder_button_events.sv @@
// Quadrature encoder and button gesture decoder. Each input beat is a 1 ms
// tick, a raw button level or a new encoder pin pair (selected by s_axis_tuser).
// A beat is taken every cycle: its state update and results are formed in one
// pass and land in a four-deep result queue, so the input stalls only while
// that queue holds more than two beats. A beat yields zero, one or two result
// beats; tlast marks the final one. Rotation results carry a signed step, all
// others a zero step. Configuration is written through cfg_wr_en/cfg_addr/
// cfg_wdata and should only change while no results are pending.
module rotary_encoder_button_events #(
    parameter int TIMER_CAP = reb_pkg::TIMER_CAP_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [reb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [reb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // button_level, pin_a, pin_b, zeros
    input  logic [1:0]                      s_axis_tuser,  // op
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,  // step[16:0], zeros
    output logic [1:0]                      m_axis_tuser,  // event_kind
    output logic                            m_axis_tlast
);
    import reb_pkg::*;

    cfg_t       cfg_reg;
    logic       accept;
    logic [1:0] res_cnt;
    res_t [1:0] res;
    res_t       head;

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accel_enable        <= 1'b0;
            cfg_reg.accel_max_step      <= 16'd1;
            cfg_reg.accel_hold_ticks    <= 8'd0;
            cfg_reg.double_click_enable <= 1'b1;
            cfg_reg.debounce_ticks      <= 8'd10;
            cfg_reg.long_press_ticks    <= TICK_W'(1000);
            cfg_reg.double_window_ticks <= TICK_W'(300);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ACCEL_ENABLE:   cfg_reg.accel_enable        <= cfg_wdata[0];
                REG_ACCEL_MAX_STEP: cfg_reg.accel_max_step      <= cfg_wdata;
                REG_ACCEL_HOLD:     cfg_reg.accel_hold_ticks    <= cfg_wdata[7:0];
                REG_DOUBLE_ENABLE:  cfg_reg.double_click_enable <= cfg_wdata[0];
                REG_DEBOUNCE:       cfg_reg.debounce_ticks      <= cfg_wdata[7:0];
                REG_LONG_PRESS:     cfg_reg.long_press_ticks    <= cfg_wdata[TICK_W-1:0];
                REG_DOUBLE_WINDOW:  cfg_reg.double_window_ticks <= cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    reb_core #(
        .TIMER_CAP(TIMER_CAP)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .accept       (accept),
        .op           (s_axis_tuser),
        .button_level (s_axis_tdata[0]),
        .pin_a        (s_axis_tdata[1]),
        .pin_b        (s_axis_tdata[2]),
        .res_cnt      (res_cnt),
        .res          (res)
    );

    reb_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (res_cnt),
        .push_data (res),
        .room      (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head)
    );

    assign m_axis_tdata = {7'd0, head.step};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule
